FILE: hdl/sgaw_pkg.sv
`timescale 1ns / 1ps

package sgaw_pkg;

  // Command codes carried on the input channel.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_NEXT  = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_PACKED = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD  = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOCAL_RANK = 4'd1;

  // One request as it enters the walker.
  typedef struct packed {
    cmd_t               command;
    logic [7:0]         target;
    logic [1:0]         levels;
    logic [31:0]        block_len;
    logic [15:0]        count_inner;
    logic [15:0]        count_outer;
    logic [63:0]        src_addr;
    logic [63:0]        dst_addr;
    logic signed [31:0] src_stride_inner;
    logic signed [31:0] src_stride_outer;
    logic signed [31:0] dst_stride_inner;
    logic signed [31:0] dst_stride_outer;
  } req_t;

  // Leaf produced by the walker, before the bases are subtracted.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  rank;
    logic [63:0] src_addr;
    logic [63:0] dst_addr;
    logic [31:0] len;
    logic        last;
  } leaf_t;

endpackage

FILE: hdl/sgaw_walker.sv
`timescale 1ns / 1ps

module sgaw_walker import sgaw_pkg::*; #(
  parameter int MAX_LEVELS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  req_t        req,
  input  logic [31:0] direct_threshold,
  output leaf_t       leaf
);

  localparam logic [1:0] MaxLvl = 2'(MAX_LEVELS);

  // Walk state and the held descriptor.
  logic               walk_active_r;
  logic [15:0]        inner_idx_r;
  logic [15:0]        outer_idx_r;
  logic [63:0]        src_run_r;
  logic [63:0]        dst_run_r;
  logic [63:0]        src_row_r;
  logic [63:0]        dst_row_r;
  logic [7:0]         h_rank_r;
  logic [31:0]        h_len_r;
  logic [15:0]        h_ci_r;
  logic [15:0]        h_co_r;
  logic signed [31:0] h_ssi_r;
  logic signed [31:0] h_sso_r;
  logic signed [31:0] h_dsi_r;
  logic signed [31:0] h_dso_r;

  logic [1:0]  lvl_c;
  logic        is_start;
  logic        packed_path;
  logic        empty_desc;
  logic        start_walk;
  logic        do_leaf;
  logic [15:0] in_ci;
  logic [15:0] in_co;

  // Values the current leaf is built from: a fresh descriptor or the held one.
  logic [15:0]        e_ii;
  logic [15:0]        e_oi;
  logic [15:0]        e_ci;
  logic [15:0]        e_co;
  logic [63:0]        e_src_run;
  logic [63:0]        e_dst_run;
  logic [63:0]        e_src_row;
  logic [63:0]        e_dst_row;
  logic signed [31:0] e_ssi;
  logic signed [31:0] e_sso;
  logic signed [31:0] e_dsi;
  logic signed [31:0] e_dso;
  logic [7:0]         e_rank;
  logic [31:0]        e_len;

  logic        inner_wrap;
  logic        outer_done;
  logic        is_last;
  logic [63:0] src_row_nxt;
  logic [63:0] dst_row_nxt;
  logic [63:0] src_step;
  logic [63:0] dst_step;

  // Decode the request and classify a start.
  always_comb begin
    lvl_c       = (req.levels > MaxLvl) ? MaxLvl : req.levels;
    is_start    = (req.command == CMD_START);
    packed_path = (req.block_len < direct_threshold);
    empty_desc  = ((lvl_c >= 2'd1) && (req.count_inner == 16'd0)) ||
                  ((lvl_c >= 2'd2) && (req.count_outer == 16'd0));
    start_walk  = is_start && !packed_path && !empty_desc;
    do_leaf     = start_walk || ((req.command == CMD_NEXT) && walk_active_r);
    in_ci       = (lvl_c < 2'd1) ? 16'd1 : req.count_inner;
    in_co       = (lvl_c < 2'd2) ? 16'd1 : req.count_outer;
  end

  // Pick the descriptor and position for this leaf.
  always_comb begin
    if (start_walk) begin
      e_ii      = 16'd0;
      e_oi      = 16'd0;
      e_ci      = in_ci;
      e_co      = in_co;
      e_src_run = req.src_addr;
      e_dst_run = req.dst_addr;
      e_src_row = req.src_addr;
      e_dst_row = req.dst_addr;
      e_ssi     = req.src_stride_inner;
      e_sso     = req.src_stride_outer;
      e_dsi     = req.dst_stride_inner;
      e_dso     = req.dst_stride_outer;
      e_rank    = req.target;
      e_len     = req.block_len;
    end else begin
      e_ii      = inner_idx_r;
      e_oi      = outer_idx_r;
      e_ci      = h_ci_r;
      e_co      = h_co_r;
      e_src_run = src_run_r;
      e_dst_run = dst_run_r;
      e_src_row = src_row_r;
      e_dst_row = dst_row_r;
      e_ssi     = h_ssi_r;
      e_sso     = h_sso_r;
      e_dsi     = h_dsi_r;
      e_dso     = h_dso_r;
      e_rank    = h_rank_r;
      e_len     = h_len_r;
    end
  end

  // Loop position: the inner index wraps into the next outer row.
  always_comb begin
    inner_wrap  = ({1'b0, e_ii} + 17'd1) >= {1'b0, e_ci};
    outer_done  = ({1'b0, e_oi} + 17'd1) >= {1'b0, e_co};
    is_last     = inner_wrap && outer_done;
    src_row_nxt = e_src_row + {{32{e_sso[31]}}, e_sso};
    dst_row_nxt = e_dst_row + {{32{e_dso[31]}}, e_dso};
    src_step    = e_src_run + {{32{e_ssi[31]}}, e_ssi};
    dst_step    = e_dst_run + {{32{e_dsi[31]}}, e_dsi};
  end

  // Result for this request.
  always_comb begin
    leaf = '0;
    leaf.kind = KIND_NONE;
    if (is_start && packed_path) begin
      leaf.kind = KIND_PACKED;
      leaf.rank = req.target;
      leaf.len  = req.block_len;
      leaf.last = 1'b1;
    end else if (is_start && empty_desc) begin
      leaf.kind = KIND_EMPTY;
      leaf.rank = req.target;
      leaf.len  = req.block_len;
      leaf.last = 1'b1;
    end else if (do_leaf) begin
      leaf.kind     = KIND_DIRECT;
      leaf.rank     = e_rank;
      leaf.src_addr = e_src_run;
      leaf.dst_addr = e_dst_run;
      leaf.len      = e_len;
      leaf.last     = is_last;
    end
  end

  // Walk control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_active_r <= 1'b0;
      inner_idx_r   <= 16'd0;
      outer_idx_r   <= 16'd0;
    end else if (accept) begin
      if (do_leaf) begin
        walk_active_r <= !is_last;
        if (inner_wrap) begin
          inner_idx_r <= 16'd0;
          outer_idx_r <= e_oi + 16'd1;
        end else begin
          inner_idx_r <= e_ii + 16'd1;
          outer_idx_r <= e_oi;
        end
      end else if (is_start) begin
        walk_active_r <= 1'b0;
      end
    end
  end

  // Running addresses and the held descriptor.
  always_ff @(posedge clk) begin
    if (accept && do_leaf) begin
      if (inner_wrap) begin
        src_row_r <= src_row_nxt;
        dst_row_r <= dst_row_nxt;
        src_run_r <= src_row_nxt;
        dst_run_r <= dst_row_nxt;
      end else begin
        src_row_r <= e_src_row;
        dst_row_r <= e_dst_row;
        src_run_r <= src_step;
        dst_run_r <= dst_step;
      end
    end
    if (accept && start_walk) begin
      h_rank_r <= req.target;
      h_len_r  <= req.block_len;
      h_ci_r   <= in_ci;
      h_co_r   <= in_co;
      h_ssi_r  <= req.src_stride_inner;
      h_sso_r  <= req.src_stride_outer;
      h_dsi_r  <= req.dst_stride_inner;
      h_dso_r  <= req.dst_stride_outer;
    end
  end

endmodule

FILE: hdl/strided_get_address_walker.sv
`timescale 1ns / 1ps
// Pipeline: an accepted request is registered in stage one, then in the output register.
// Throughput: one request per cycle unless out_stall holds a full output register; the walk
// step and base table read are registered in stage one, the base subtraction in a second register stage.
// Reset: synchronous, active low; clears the walk, the pipeline valids and the
// configuration registers. The base table is not cleared and needs loading.
module strided_get_address_walker import sgaw_pkg::*; #(
  parameter int NUM_RANKS  = 256,
  parameter int MAX_LEVELS = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic [7:0]            in_target,
  input  logic [1:0]            in_levels,
  input  logic [31:0]           in_block_len,
  input  logic [15:0]           in_count_inner,
  input  logic [15:0]           in_count_outer,
  input  logic [63:0]           in_src_addr,
  input  logic [63:0]           in_dst_addr,
  input  logic signed [31:0]    in_src_stride_inner,
  input  logic signed [31:0]    in_src_stride_outer,
  input  logic signed [31:0]    in_dst_stride_inner,
  input  logic signed [31:0]    in_dst_stride_outer,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_dest_rank,
  output logic [63:0]           out_src_offset,
  output logic [63:0]           out_dst_offset,
  output logic [31:0]           out_length,
  output logic                  out_last,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]           cfg_data
);

  localparam int RW = (NUM_RANKS > 1) ? $clog2(NUM_RANKS) : 1;

  logic        accept;
  logic        s1_adv;
  req_t        req;
  leaf_t       leaf;

  logic [31:0] threshold_r;
  logic [7:0]  local_rank_r;

  logic [63:0] base_mem [NUM_RANKS];
  logic [RW-1:0] src_idx;
  logic [RW-1:0] dst_idx;
  logic        src_ok;
  logic        dst_ok;

  logic        s1_valid_r;
  leaf_t       s1_leaf_r;
  logic        s1_src_ok_r;
  logic        s1_dst_ok_r;
  logic [63:0] s1_src_base_r;
  logic [63:0] s1_dst_base_r;
  logic [63:0] src_base;
  logic [63:0] dst_base;

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        s1_valid_nxt;
  kind_t       out_kind_r;
  logic [7:0]  out_rank_r;
  logic [63:0] out_src_offset_r;
  logic [63:0] out_dst_offset_r;
  logic [31:0] out_len_r;
  logic        out_last_r;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= 32'd0;
      local_rank_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_THRESHOLD:  threshold_r  <= cfg_data;
        CFG_LOCAL_RANK: local_rank_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage one moves on whenever the output register is free or taken.
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign req.command          = cmd_t'(in_command);
  assign req.target           = in_target;
  assign req.levels           = in_levels;
  assign req.block_len        = in_block_len;
  assign req.count_inner      = in_count_inner;
  assign req.count_outer      = in_count_outer;
  assign req.src_addr         = in_src_addr;
  assign req.dst_addr         = in_dst_addr;
  assign req.src_stride_inner = in_src_stride_inner;
  assign req.src_stride_outer = in_src_stride_outer;
  assign req.dst_stride_inner = in_dst_stride_inner;
  assign req.dst_stride_outer = in_dst_stride_outer;

  sgaw_walker #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_walker (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .req              (req),
    .direct_threshold (threshold_r),
    .leaf             (leaf)
  );

  // Ranks outside the table read as base zero.
  assign src_idx = RW'(leaf.rank);
  assign dst_idx = RW'(local_rank_r);
  assign src_ok  = ({24'd0, leaf.rank} < 32'(NUM_RANKS));
  assign dst_ok  = ({24'd0, local_rank_r} < 32'(NUM_RANKS));

  // Base table: one write port for loads, two registered read ports.
  always_ff @(posedge clk) begin
    if (accept && (req.command == CMD_LOAD) &&
        ({24'd0, in_target} < 32'(NUM_RANKS))) begin
      base_mem[RW'(in_target)] <= in_src_addr;
    end
    if (accept) begin
      s1_src_base_r <= base_mem[src_idx];
      s1_dst_base_r <= base_mem[dst_idx];
    end
  end

  // Stage one: the leaf waits here for its bases.
  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_leaf_r   <= leaf;
      s1_src_ok_r <= src_ok;
      s1_dst_ok_r <= dst_ok;
    end
  end

  // Displacements are only formed for direct leaves.
  always_comb begin
    src_base = s1_src_ok_r ? s1_src_base_r : 64'd0;
    dst_base = s1_dst_ok_r ? s1_dst_base_r : 64'd0;
  end

  // Output register.
  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_kind_r <= s1_leaf_r.kind;
      out_rank_r <= s1_leaf_r.rank;
      out_len_r  <= s1_leaf_r.len;
      out_last_r <= s1_leaf_r.last;
      if (s1_leaf_r.kind == KIND_DIRECT) begin
        out_src_offset_r <= s1_leaf_r.src_addr - src_base;
        out_dst_offset_r <= s1_leaf_r.dst_addr - dst_base;
      end else begin
        out_src_offset_r <= 64'd0;
        out_dst_offset_r <= 64'd0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_dest_rank  = out_rank_r;
  assign out_src_offset = out_src_offset_r;
  assign out_dst_offset = out_dst_offset_r;
  assign out_length     = out_len_r;
  assign out_last       = out_last_r;

  // Checks on the pipeline and on the result encoding.
  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (!rst_n) in_stall |-> (s1_valid_r && out_valid_r)
  ) else $error("request stalled with a free stage");

  a_s1_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_leaf_r))
  ) else $error("stage one changed while held");

  a_none_is_blank: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_NONE)) |->
      (!out_last && (out_dest_rank == 8'd0) && (out_length == 32'd0))
  ) else $error("no-result carries data");

  a_short_paths_last: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_kind == KIND_PACKED) || (out_kind == KIND_EMPTY))) |->
      (out_last && (out_src_offset == 64'd0) && (out_dst_offset == 64'd0))
  ) else $error("packed or empty result malformed");

endmodule
